[design/tpme_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpme_pkg;

   localparam int POP_W   = 32;
   localparam int DIR_W   = 3;
   localparam int ACC_W   = 40;
   localparam int K_W     = 32;
   localparam int HALF_W  = 20;
   localparam int DENS_W  = 37;
   localparam int VEL_W   = 32;
   localparam int PHASE_W = 30;
   localparam int REQ_W   = 80;
   localparam int RSP_W   = 240;
   localparam int CSR_IDX_W = 1;

   localparam logic [K_W-1:0] K_RESET = 32'h1000_0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RED  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_BLUE = 1'b1;

   // quotient selects
   localparam logic [1:0] DIV_VX    = 2'd0;
   localparam logic [1:0] DIV_VY    = 2'd1;
   localparam logic [1:0] DIV_VZ    = 2'd2;
   localparam logic [1:0] DIV_PHASE = 2'd3;

   // scaling multiplier steps
   localparam logic [1:0] MUL_RED_LO  = 2'd0;
   localparam logic [1:0] MUL_RED_HI  = 2'd1;
   localparam logic [1:0] MUL_BLUE_LO = 2'd2;
   localparam logic [1:0] MUL_BLUE_HI = 2'd3;

   typedef struct packed {
      logic       acc_en;
      logic       snap;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       div_start;
      logic [1:0] div_sel;
      logic       div_store;
      logic       load_out;
   } tpme_cmd_type;

   typedef struct packed {
      logic div_busy;
   } tpme_status_type;

   // saturate a 41-bit signed sum to the density width
   function automatic logic [DENS_W-1:0] sat_dens(input logic [ACC_W:0] v);
      logic [ACC_W-DENS_W+1:0] top;
      top = v[ACC_W:DENS_W-1];
      if (top == '0 || top == '1) begin
         return v[DENS_W-1:0];
      end else if (v[ACC_W]) begin
         return {1'b1, {(DENS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DENS_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

[design/tpme_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpme_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tlast,
   output logic                          req_tready,
   input  wire logic                     rsp_tready,
   output logic                          rsp_tvalid,
   output tpme_pkg::tpme_cmd_type        cmd,
   input  wire tpme_pkg::tpme_status_type status
);

   typedef enum logic [2:0] {
      ST_ACC,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_RUN,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic [1:0] sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            req_tready = 1'b1;
            cmd.acc_en = req_tvalid;
            cmd.snap   = req_tvalid && req_tlast;
            if (cmd.snap) begin
               state_in = ST_MUL;
               step_in  = tpme_pkg::MUL_RED_LO;
            end
         end
         ST_MUL: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = step_ff;
            step_in      = step_ff + 2'd1;
            if (step_ff == tpme_pkg::MUL_BLUE_HI) begin
               state_in = ST_DIV_GO;
               sel_in   = tpme_pkg::DIV_VX;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sel_ff;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_sel = sel_ff;
            if (!status.div_busy) begin
               cmd.div_store = 1'b1;
               sel_in        = sel_ff + 2'd1;
               state_in      = (sel_ff == tpme_pkg::DIV_PHASE) ? ST_OUT : ST_DIV_GO;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         step_ff      <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider not busy after start");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result load lost");

   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACC) |-> !cmd.acc_en && !cmd.snap)
      else $error("accumulate outside accept phase");

endmodule

`default_nettype wire

[design/tpme_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpme_dp #(
   parameter int FRAC_BITS = 28
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [tpme_pkg::POP_W-1:0]            pop_red,
   input  wire logic [tpme_pkg::POP_W-1:0]            pop_blue,
   input  wire logic [tpme_pkg::DIR_W-1:0]            dir_x,
   input  wire logic [tpme_pkg::DIR_W-1:0]            dir_y,
   input  wire logic [tpme_pkg::DIR_W-1:0]            dir_z,
   input  wire logic                                  csr_we,
   input  wire logic [tpme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [tpme_pkg::K_W-1:0]              csr_wdata,
   input  wire tpme_pkg::tpme_cmd_type                cmd,
   output tpme_pkg::tpme_status_type                  status,
   output logic [tpme_pkg::RSP_W-1:0]                 rsp_tdata
);

   localparam int ACC_W  = tpme_pkg::ACC_W;
   localparam int PROD_W = tpme_pkg::ACC_W + tpme_pkg::K_W;
   localparam int SCL_W  = PROD_W - FRAC_BITS;
   localparam int NUM_W  = SCL_W + 2;
   localparam int DVD_W  = NUM_W + FRAC_BITS;
   localparam int REM_W  = NUM_W + 1;
   localparam int CNT_W  = $clog2(DVD_W + 1);
   localparam int PP_W   = tpme_pkg::HALF_W + tpme_pkg::K_W;
   localparam int VEL_W  = tpme_pkg::VEL_W;

   // configuration
   logic [tpme_pkg::K_W-1:0] kr_ff, kb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kr_ff <= tpme_pkg::K_RESET;
         kb_ff <= tpme_pkg::K_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tpme_pkg::CSR_INV_RED:  kr_ff <= csr_wdata;
            tpme_pkg::CSR_INV_BLUE: kb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // accumulation
   logic [ACC_W-1:0] sr_ff, sb_ff, mx_ff, my_ff, mz_ff;
   logic [ACC_W-1:0] sr_in, sb_in, mx_in, my_in, mz_in;
   logic [32:0]      pt;
   logic [35:0]      px, py, pz;

   assign pt = {pop_red[31], pop_red} + {pop_blue[31], pop_blue};
   assign px = {{3{pt[32]}}, pt} * {{33{dir_x[2]}}, dir_x};
   assign py = {{3{pt[32]}}, pt} * {{33{dir_y[2]}}, dir_y};
   assign pz = {{3{pt[32]}}, pt} * {{33{dir_z[2]}}, dir_z};

   assign sr_in = sr_ff + {{(ACC_W-32){pop_red[31]}}, pop_red};
   assign sb_in = sb_ff + {{(ACC_W-32){pop_blue[31]}}, pop_blue};
   assign mx_in = mx_ff + {{(ACC_W-36){px[35]}}, px};
   assign my_in = my_ff + {{(ACC_W-36){py[35]}}, py};
   assign mz_in = mz_ff + {{(ACC_W-36){pz[35]}}, pz};

   // snapshot of one node
   logic [ACC_W-1:0] snr_ff, snb_ff, snx_ff, sny_ff, snz_ff;
   logic [ACC_W:0]   rho_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff <= '0; sb_ff <= '0;
         mx_ff <= '0; my_ff <= '0; mz_ff <= '0;
      end else if (cmd.snap) begin
         sr_ff <= '0; sb_ff <= '0;
         mx_ff <= '0; my_ff <= '0; mz_ff <= '0;
      end else if (cmd.acc_en) begin
         sr_ff <= sr_in; sb_ff <= sb_in;
         mx_ff <= mx_in; my_ff <= my_in; mz_ff <= mz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         snr_ff <= sr_in;
         snb_ff <= sb_in;
         snx_ff <= mx_in;
         sny_ff <= my_in;
         snz_ff <= mz_in;
         rho_ff <= {sr_in[ACC_W-1], sr_in} + {sb_in[ACC_W-1], sb_in};
      end
   end

   // density scaling: 20 x 32 partial products, two per density
   logic [ACC_W-1:0]             ms, um;
   logic [tpme_pkg::K_W-1:0]     km;
   logic [tpme_pkg::HALF_W-1:0]  half;
   logic [PP_W-1:0]              pp;
   logic [PROD_W-1:0]            prod_ff, prod_sum;
   logic [SCL_W-1:0]             smag;
   logic [SCL_W:0]               sval, a_ff, b_ff;

   assign ms   = cmd.mul_step[1] ? snb_ff : snr_ff;
   assign km   = cmd.mul_step[1] ? kb_ff : kr_ff;
   assign um   = ms[ACC_W-1] ? (~ms + 1'b1) : ms;
   assign half = cmd.mul_step[0] ? um[ACC_W-1:tpme_pkg::HALF_W] : um[tpme_pkg::HALF_W-1:0];
   assign pp   = PP_W'(half) * PP_W'(km);
   assign prod_sum = prod_ff + (PROD_W'(pp) << tpme_pkg::HALF_W);
   assign smag = prod_sum[PROD_W-1:FRAC_BITS];
   assign sval = ms[ACC_W-1] ? (~{1'b0, smag} + 1'b1) : {1'b0, smag};

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_step)
            tpme_pkg::MUL_RED_LO, tpme_pkg::MUL_BLUE_LO: prod_ff <= PROD_W'(pp);
            tpme_pkg::MUL_RED_HI: a_ff <= sval;
            default:              b_ff <= sval;
         endcase
      end
   end

   // divider operand select
   logic [NUM_W-1:0] n_sel, d_sel, a_x, b_x;

   assign a_x = {a_ff[SCL_W], a_ff};
   assign b_x = {b_ff[SCL_W], b_ff};

   always_comb begin
      case (cmd.div_sel)
         tpme_pkg::DIV_VX: n_sel = {{(NUM_W-ACC_W){snx_ff[ACC_W-1]}}, snx_ff};
         tpme_pkg::DIV_VY: n_sel = {{(NUM_W-ACC_W){sny_ff[ACC_W-1]}}, sny_ff};
         tpme_pkg::DIV_VZ: n_sel = {{(NUM_W-ACC_W){snz_ff[ACC_W-1]}}, snz_ff};
         default:          n_sel = a_x - b_x;
      endcase
      if (cmd.div_sel == tpme_pkg::DIV_PHASE) begin
         d_sel = a_x + b_x;
      end else begin
         d_sel = {{(NUM_W-ACC_W-1){rho_ff[ACC_W]}}, rho_ff};
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DVD_W-1:0] dvd_ff;
   logic [REM_W-1:0] rem_ff, rem_sh;
   logic [NUM_W-1:0] ud_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, neg_ff, zero_ff, npos_ff, nneg_ff;
   logic             ge;
   logic [NUM_W-1:0] un_sel, ud_sel;

   assign un_sel = n_sel[NUM_W-1] ? (~n_sel + 1'b1) : n_sel;
   assign ud_sel = d_sel[NUM_W-1] ? (~d_sel + 1'b1) : d_sel;
   assign rem_sh = {rem_ff[REM_W-2:0], dvd_ff[DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, ud_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff  <= {un_sel, {FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         ud_ff   <= ud_sel;
         cnt_ff  <= CNT_W'(DVD_W);
         neg_ff  <= n_sel[NUM_W-1] ^ d_sel[NUM_W-1];
         zero_ff <= (d_sel == '0);
         npos_ff <= !n_sel[NUM_W-1] && (n_sel != '0);
         nneg_ff <= n_sel[NUM_W-1];
      end else if (busy_ff) begin
         rem_ff <= ge ? (rem_sh - {1'b0, ud_ff}) : rem_sh;
         dvd_ff <= {dvd_ff[DVD_W-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign status.div_busy = busy_ff;

   // saturate and sign the quotient
   logic [VEL_W-1:0] lim_pos, lim_neg, lim, qmag, qval;

   always_comb begin
      if (cmd.div_sel == tpme_pkg::DIV_PHASE) begin
         lim_pos = VEL_W'((64'd1 << (tpme_pkg::PHASE_W - 1)) - 64'd1);
         lim_neg = VEL_W'(64'd1 << (tpme_pkg::PHASE_W - 1));
      end else begin
         lim_pos = VEL_W'((64'd1 << (VEL_W - 1)) - 64'd1);
         lim_neg = VEL_W'(64'd1 << (VEL_W - 1));
      end
      lim  = neg_ff ? lim_neg : lim_pos;
      qmag = (dvd_ff > DVD_W'(lim)) ? lim : dvd_ff[VEL_W-1:0];
      if (zero_ff) begin
         if (npos_ff) begin
            qval = lim_pos;
         end else if (nneg_ff) begin
            qval = ~lim_neg + 1'b1;
         end else begin
            qval = '0;
         end
      end else begin
         qval = neg_ff ? (~qmag + 1'b1) : qmag;
      end
   end

   logic [VEL_W-1:0]            vx_ff, vy_ff, vz_ff;
   logic [tpme_pkg::PHASE_W-1:0] ph_ff;
   logic                        fault_ff;

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         fault_ff <= 1'b0;
      end else if (cmd.div_store) begin
         fault_ff <= fault_ff | zero_ff;
      end
      if (cmd.div_store) begin
         case (cmd.div_sel)
            tpme_pkg::DIV_VX: vx_ff <= qval;
            tpme_pkg::DIV_VY: vy_ff <= qval;
            tpme_pkg::DIV_VZ: vz_ff <= qval;
            default:          ph_ff <= qval[tpme_pkg::PHASE_W-1:0];
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_tdata <= {2'b00, fault_ff, ph_ff, vz_ff, vy_ff, vx_ff,
                       tpme_pkg::sat_dens({snb_ff[ACC_W-1], snb_ff}),
                       tpme_pkg::sat_dens({snr_ff[ACC_W-1], snr_ff}),
                       tpme_pkg::sat_dens(rho_ff)};
      end
   end

endmodule

`default_nettype wire

[design/two_phase_moment_extraction.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// req_*     in         one direction's populations and lattice velocity
// rsp_*     out        one node's densities, velocity, phase field, fault
// csr_*     in         reciprocal reference densities (write only)
//
// Non-last transfers are absorbed one per cycle into the accumulators.
// A last transfer is followed by density scaling on a 20x32 multiplier in
// red-low, red-high, blue-low and blue-high steps, then four serial
// divisions on one shared restoring divider; req_tready is low meanwhile.
// The result waits in its register while a new node streams in.
// Reset is synchronous: it clears accumulators and sets both reciprocals to 1.0.

module two_phase_moment_extraction #(
   parameter int FRAC_BITS = 28
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // pop_red[31:0], pop_blue[63:32], dir_x[66:64], dir_y[69:67], dir_z[72:70]
   input  wire logic [tpme_pkg::REQ_W-1:0]        req_tdata,
   input  wire logic                              req_tlast,   // last_dir
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // density_total[36:0], density_red[73:37], density_blue[110:74],
   // vel_x[142:111], vel_y[174:143], vel_z[206:175], phase_field[236:207],
   // div_fault[237]
   output logic [tpme_pkg::RSP_W-1:0]             rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [tpme_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tpme_pkg::K_W-1:0]          csr_wdata
);

   tpme_pkg::tpme_cmd_type    cmd;
   tpme_pkg::tpme_status_type status;

   // sequence accumulate, scale, divide and result hand-off
   tpme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd),
      .status     (status)
   );

   // unpack the request fields and hold all arithmetic
   tpme_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .pop_red   (req_tdata[31:0]),
      .pop_blue  (req_tdata[63:32]),
      .dir_x     (req_tdata[66:64]),
      .dir_y     (req_tdata[69:67]),
      .dir_z     (req_tdata[72:70]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

[verif/two_phase_moment_extraction_test.sv]
`timescale 1ns / 1ps

// one direction as the sender offers it
typedef struct {
   logic signed [31:0] pr;
   logic signed [31:0] pb;
   logic signed [2:0]  dx;
   logic signed [2:0]  dy;
   logic signed [2:0]  dz;
   bit                 last;
} dir_item_type;

// Node moment tracker: follows the block's accumulators and builds the
// expected per-node result when a direction marked last is accepted.
class node_moment_board;
   localparam int FRAC = 28;

   int unsigned k_red  = 32'h1000_0000;
   int unsigned k_blue = 32'h1000_0000;
   longint acc_red, acc_blue, acc_mx, acc_my, acc_mz;
   logic [tpme_pkg::RSP_W-1:0] node_q[$];
   int  errors;
   bit  fault_seen;

   function longint wrap40(longint v);
      logic signed [39:0] t;
      t = v[39:0];
      return t;
   endfunction

   function longint sat_to(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   // (m * k) >> FRAC, truncated toward zero
   function longint scale_dens(longint m, int unsigned k);
      logic [79:0] um, p;
      um = (m < 0) ? -m : m;
      p = um * k;
      p = p >> FRAC;
      return (m < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   // n * 2^FRAC / d, toward zero, saturated to w signed bits
   function longint quotient(longint n, longint d, int w);
      logic [127:0] un, ud, q, maxp, lim;
      bit neg;
      maxp = (128'd1 << (w - 1)) - 1;
      if (d == 0) begin
         fault_seen = 1;
         if (n > 0) return longint'(maxp[63:0]);
         if (n < 0) return -longint'(maxp[63:0]) - 1;
         return 0;
      end
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      lim = neg ? maxp + 1 : maxp;
      q = (un << FRAC) / ud;
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function void set_reg(logic idx, int unsigned val);
      if (idx == tpme_pkg::CSR_INV_RED) k_red = val;
      else k_blue = val;
   endfunction

   function void note_input(dir_item_type it);
      longint pt, rho, a, b;
      logic [tpme_pkg::RSP_W-1:0] e;
      pt = longint'(it.pr) + longint'(it.pb);
      acc_red  = wrap40(acc_red + it.pr);
      acc_blue = wrap40(acc_blue + it.pb);
      acc_mx   = wrap40(acc_mx + pt * longint'(it.dx));
      acc_my   = wrap40(acc_my + pt * longint'(it.dy));
      acc_mz   = wrap40(acc_mz + pt * longint'(it.dz));
      if (!it.last) return;
      rho = acc_red + acc_blue;
      a = scale_dens(acc_red, k_red);
      b = scale_dens(acc_blue, k_blue);
      fault_seen = 0;
      e = '0;
      e[36:0]    = 37'(sat_to(rho, 37));
      e[73:37]   = 37'(sat_to(acc_red, 37));
      e[110:74]  = 37'(sat_to(acc_blue, 37));
      e[142:111] = 32'(quotient(acc_mx, rho, 32));
      e[174:143] = 32'(quotient(acc_my, rho, 32));
      e[206:175] = 32'(quotient(acc_mz, rho, 32));
      e[236:207] = 30'(quotient(a - b, a + b, 30));
      e[237]     = fault_seen;
      node_q.push_back(e);
      acc_red = 0; acc_blue = 0; acc_mx = 0; acc_my = 0; acc_mz = 0;
   endfunction

   function void check_result(logic [tpme_pkg::RSP_W-1:0] act);
      int    lsb[8] = '{0, 37, 74, 111, 143, 175, 207, 237};
      int    wid[8] = '{37, 37, 37, 32, 32, 32, 30, 1};
      string nm[8]  = '{"density_total", "density_red", "density_blue", "vel_x",
                        "vel_y", "vel_z", "phase_field", "div_fault"};
      logic [tpme_pkg::RSP_W-1:0] e;
      logic [63:0] fe, fa, mask;
      if (node_q.size() == 0) begin
         $display("%0t unexpected result transfer, actual %h", $time, act);
         errors++;
         return;
      end
      e = node_q.pop_front();
      for (int i = 0; i < 8; i++) begin
         mask = (64'd1 << wid[i]) - 1;
         fe = 64'(e >> lsb[i]) & mask;
         fa = 64'(act >> lsb[i]) & mask;
         if (fe !== fa) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, nm[i], fe, fa);
            errors++;
         end
      end
   endfunction
endclass

module two_phase_moment_extraction_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic signed [31:0] POP_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] POP_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE = 32'sh1000_0000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [tpme_pkg::REQ_W-1:0]  req_tdata = '0;
   logic              req_tlast = 0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [tpme_pkg::RSP_W-1:0]  rsp_tdata;
   logic              csr_we = 0;
   logic [tpme_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tpme_pkg::K_W-1:0]    csr_wdata = '0;

   node_moment_board board = new();
   int tx_idle = 11;
   int rx_idle = 83;
   int hold_seq = 0;     // bump to ask the receiver for a long hold-off
   int hold_seen = 0;
   int hold_left = 0;
   longint cycles = 0;

   two_phase_moment_extraction i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = 1500;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle);
      end
   end

   // check every result transfer against the oldest expected node
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // offer one direction; hold valid high across back-to-back transfers
   task automatic send_dir(dir_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, it.dz, it.dy, it.dx, it.pb, it.pr};
      req_tlast  <= it.last;
      do @(posedge clock); while (!req_tready);
      board.note_input(it);
   endtask

   task automatic send_node(logic signed [31:0] pr, logic signed [31:0] pb,
                            int dx, int dy, int dz, int len);
      dir_item_type it;
      for (int i = 0; i < len; i++) begin
         it.pr = pr; it.pb = pb;
         it.dx = 3'(dx); it.dy = 3'(dy); it.dz = 3'(dz);
         it.last = (i == len - 1);
         send_dir(it);
      end
   endtask

   function automatic logic signed [31:0] rand_pop();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) return $urandom;
      if (sel < 55) return $urandom_range(0, 65535) - 32768;
      if (sel < 62) return POP_MAX;
      if (sel < 69) return POP_MIN;
      if (sel < 76) return 0;
      return $urandom_range(0, 32'h2000_0000);
   endfunction

   // a well-formed node of random directions; some nodes balance red
   // against blue so the total density cancels
   task automatic send_rand_node(output int sent);
      dir_item_type it;
      int  len;
      bit  balanced;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
      balanced = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < len; i++) begin
         it.pr = rand_pop();
         it.pb = balanced ? -it.pr : rand_pop();
         it.dx = 3'($urandom_range(0, 6) - 3);
         it.dy = 3'($urandom_range(0, 6) - 3);
         it.dz = 3'($urandom_range(0, 6) - 3);
         it.last = (i == len - 1);
         send_dir(it);
      end
      sent = len;
   endtask

   task automatic write_reg(logic [tpme_pkg::CSR_IDX_W-1:0] idx,
                            logic [tpme_pkg::K_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drain: every node result back, then let the back end settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.node_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sent, total;
      logic [tpme_pkg::K_W-1:0] kr, kb;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed nodes at reset reciprocals
      send_node(0, 0, 0, 0, 0, 1);                    // zero density: all faults
      send_node(POP_MAX, POP_MAX, 3, -3, 0, 1);
      send_node(POP_MIN, POP_MIN, -3, 3, 1, 1);
      send_node(POP_MAX, POP_MIN, 3, 3, 3, 1);         // near-zero total density
      send_node(ONE, -ONE, 2, -1, 1, 2);               // cancelled density
      send_node(1, 0, -3, -3, -3, 1);                  // tiny density, huge velocity
      send_node(POP_MAX, POP_MAX, 1, 2, -2, 17);       // total density saturates
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin kr = tpme_pkg::K_RESET; kb = tpme_pkg::K_RESET; end
            1: begin kr = '0; kb = '0; end
            2: begin kr = '1; kb = '1; end
            3: begin kr = 32'h1000_0000; kb = 32'h0800_0000; end
            4: begin kr = $urandom; kb = '0; end
            default: begin kr = $urandom; kb = $urandom; end
         endcase
         write_reg(tpme_pkg::CSR_INV_RED, kr);
         write_reg(tpme_pkg::CSR_INV_BLUE, kb);
         if (ph < 2) begin
            tx_idle = 11; rx_idle = 83;
         end else if (ph < 4) begin
            tx_idle = 83; rx_idle = 11;
         end else begin
            tx_idle = 0; rx_idle = 0;
         end
         // long receiver hold-off while the sender keeps offering
         if (ph == 4) hold_seq++;
         total = 0;
         while (total < 60) begin
            send_rand_node(sent);
            total += sent;
         end
         drain();
      end

      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
